FILE: rtl/dpq_pkg.sv
// Shared constants, types and codes for the deduplicating priority queue.
`default_nettype none

package dpq_pkg;

	// Queue geometry
	localparam int DEPTH     = 64;
	localparam int PRIO_BITS = 16;
	localparam int DATA_BITS = 16;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [PRIO_BITS-1:0] prio_t;
	typedef logic        [DATA_BITS-1:0] data_t;
	typedef logic        [IDX_W-1:0]     idx_t;
	typedef logic        [CNT_W-1:0]     cnt_t;

	// Item kinds on the input side
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_ADDED   = 3'd0;
	localparam status_t ST_FULL    = 3'd1;
	localparam status_t ST_DUP     = 3'd2;
	localparam status_t ST_REMOVED = 3'd3;
	localparam status_t ST_EMPTY   = 3'd4;

	// Scan token handed from cell to cell
	typedef struct packed {
		logic  valid;
		logic  has;
		logic  found;
		prio_t best_prio;
		data_t best_data;
		idx_t  best_idx;
	} tok_t;

	// Broadcast command from the controller to every cell
	typedef struct packed {
		logic  append;
		logic  shift;
		idx_t  shift_idx;
		cnt_t  count;
		prio_t op_prio;
		data_t op_data;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/dpq_cell.sv
// One storage cell of the queue: holds an entry and processes the scan token.
`default_nettype none

module dpq_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dpq_pkg::cnt_t cell_id,
	input  wire dpq_pkg::cmd_t cmd,
	input  wire dpq_pkg::tok_t tin,
	input  wire dpq_pkg::prio_t nxt_prio,
	input  wire dpq_pkg::data_t nxt_data,
	output dpq_pkg::prio_t     prio,
	output dpq_pkg::data_t     data,
	output dpq_pkg::tok_t      tout
);
	import dpq_pkg::*;

	prio_t prio_q;
	data_t data_q;
	tok_t  tok_q;
	tok_t  tok_d;
	logic  in_use;
	logic  match;
	logic  take_mine;
	logic  do_shift;
	logic  do_append;

	assign in_use    = cell_id < cmd.count;
	assign match     = (prio_q == cmd.op_prio) && (data_q == cmd.op_data);
	assign take_mine = !tin.has || (prio_q > tin.best_prio);
	assign do_append = cmd.append && (cell_id == cmd.count);
	assign do_shift  = cmd.shift && (cell_id >= cnt_t'(cmd.shift_idx))
		&& (cnt_t'(cell_id + cnt_t'(1)) < cmd.count);

	// Fold this entry into the passing token; drop it past the last entry
	always_comb begin
		tok_d = tin;
		tok_d.valid = tin.valid && in_use;
		if (tin.valid && in_use) begin
			tok_d.found = tin.found || match;
			tok_d.has   = 1'b1;
			if (take_mine) begin
				tok_d.best_prio = prio_q;
				tok_d.best_data = data_q;
				tok_d.best_idx  = idx_t'(cell_id);
			end
		end
	end

	// Advance the token one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// Load an appended entry or take the neighbor's entry to close a gap
	always_ff @(posedge clk) begin
		if (do_append) begin
			prio_q <= cmd.op_prio;
			data_q <= cmd.op_data;
		end else if (do_shift) begin
			prio_q <= nxt_prio;
			data_q <= nxt_data;
		end
	end

	assign prio = prio_q;
	assign data = data_q;
	assign tout = tok_q;

endmodule

`default_nettype wire

FILE: rtl/dedup_priority_queue_top.sv
// Top level of the deduplicating priority queue: controller and cell chain.
//
// Input stream (s_*): one item per operation. s_tuser is the mode (0 insert,
// 1 remove); s_tdata carries the priority and data word of an insert.
// Output stream (m_*): exactly one result item per input item, in order.
// m_tuser is the status (added, full, duplicate, removed, empty); m_tdata
// carries the removed data word, the not-empty flag and the fill count.
// Entries sit in a chain of cells in insertion order. A scan token walks the
// chain one cell per cycle, collecting the duplicate match and the oldest
// highest-priority entry; a remove then closes the gap by shifting down.
// The result is known without a scan when the queue is empty or a full queue
// sees an insert; otherwise the token walks over the N stored entries, where N
// is the fill count before the item. One item is in work at a time; the next
// is accepted the cycle after its result is loaded into the output register.
// A stalled receiver holds the result in the output register; the block
// takes the next item and finishes it, then waits until the output is free.
// Reset empties the queue and clears the output; no clearing pass is needed.
`default_nettype none

module dedup_priority_queue_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // prio_in[15:0], data_in[31:16]
	input  wire logic        s_tuser,  // mode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // data_out[15:0], not_empty[16], fill_count[23:17], zero[31:24]
	output logic       [2:0] m_tuser   // status[2:0]
);
	import dpq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t  state_q;
	logic    op_mode_q;
	prio_t   op_prio_q;
	data_t   op_data_q;
	cnt_t    count_q;
	status_t res_status_q;
	logic [15:0] res_data_q;
	logic    m_tvalid_q;
	logic [31:0] m_tdata_q;
	status_t m_tuser_q;

	cmd_t  cmd;
	tok_t  inj;
	tok_t  fin;
	tok_t  tok  [DEPTH];
	tok_t  tin  [DEPTH];
	prio_t prio [DEPTH];
	data_t data [DEPTH];
	prio_t nprio[DEPTH];
	data_t ndata[DEPTH];
	logic [DEPTH-1:0] tok_valid;
	logic  inject;
	logic  out_free;

	assign out_free = !m_tvalid_q || m_tready;

	// Start a scan unless the answer is known without one
	assign inject = (state_q == S_DECIDE) && (count_q != cnt_t'(0))
		&& ((op_mode_q == MODE_REMOVE) || (count_q != cnt_t'(DEPTH)));

	always_comb begin
		inj = '0;
		inj.valid = inject;
	end

	// Collect the token at the last stored entry
	always_comb begin
		fin = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tok_valid[i] = tok[i].valid;
			if (tok[i].valid && (cnt_t'(i + 1) == count_q)) begin
				fin = tok[i];
			end
		end
	end

	// Broadcast the update to the cells
	always_comb begin
		cmd = '0;
		cmd.count   = count_q;
		cmd.op_prio = op_prio_q;
		cmd.op_data = op_data_q;
		cmd.append  = ((state_q == S_DECIDE) && (op_mode_q == MODE_INSERT)
			&& (count_q == cnt_t'(0)))
			|| ((state_q == S_SCAN) && fin.valid && (op_mode_q == MODE_INSERT)
			&& !fin.found);
		cmd.shift     = (state_q == S_SCAN) && fin.valid && (op_mode_q == MODE_REMOVE);
		cmd.shift_idx = fin.best_idx;
	end

	// Chain wiring: token flows up, entries shift down
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			tin[i]   = (i == 0) ? inj : tok[(i == 0) ? 0 : i - 1];
			nprio[i] = (i == DEPTH - 1) ? '0 : prio[(i == DEPTH - 1) ? i : i + 1];
			ndata[i] = (i == DEPTH - 1) ? '0 : data[(i == DEPTH - 1) ? i : i + 1];
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		dpq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_id  (cnt_t'(g)),
			.cmd      (cmd),
			.tin      (tin[g]),
			.nxt_prio (nprio[g]),
			.nxt_data (ndata[g]),
			.prio     (prio[g]),
			.data     (data[g]),
			.tout     (tok[g])
		);
	end

	// Sequence one item: accept, decide, scan, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_mode_q    <= MODE_INSERT;
			op_prio_q    <= '0;
			op_data_q    <= '0;
			count_q      <= '0;
			res_status_q <= ST_ADDED;
			res_data_q   <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= ST_ADDED;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_mode_q <= s_tuser;
						op_prio_q <= prio_t'($signed(s_tdata[15:0]));
						op_data_q <= data_t'(s_tdata[31:16]);
						state_q   <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					res_data_q <= '0;
					if (op_mode_q == MODE_INSERT) begin
						if (count_q == cnt_t'(DEPTH)) begin
							res_status_q <= ST_FULL;
							state_q      <= S_EMIT;
						end else if (count_q == cnt_t'(0)) begin
							res_status_q <= ST_ADDED;
							count_q      <= cnt_t'(count_q + cnt_t'(1));
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (count_q == cnt_t'(0)) begin
						res_status_q <= ST_EMPTY;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (fin.valid) begin
						if (op_mode_q == MODE_INSERT) begin
							if (fin.found) begin
								res_status_q <= ST_DUP;
							end else begin
								res_status_q <= ST_ADDED;
								count_q      <= cnt_t'(count_q + cnt_t'(1));
							end
						end else begin
							res_status_q <= ST_REMOVED;
							res_data_q   <= 16'(fin.best_data);
							count_q      <= cnt_t'(count_q - cnt_t'(1));
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {8'h00, 7'(count_q), (count_q != cnt_t'(0)), res_data_q};
						m_tuser_q  <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Fill count stays within the chain
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("fill count beyond depth");

	// Only one scan token is alive at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one scan token");

	// A finished token only appears while scanning
	a_fin_scan: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid |-> (state_q == S_SCAN))
		else $error("token finished outside scan");

	// Append and shift never happen together
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.append && cmd.shift))
		else $error("append and shift at once");

	// An append during a scan grows the fill count by one
	a_add_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && cmd.append) |=> (count_q == cnt_t'($past(count_q) + cnt_t'(1))))
		else $error("append did not grow the fill count");

endmodule

`default_nettype wire
